// ===== rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the tick timer bank.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int TICK_W = 26;
	localparam int CH_W   = 5;
	localparam int MS_W   = 32;
	localparam int FUNC_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

	localparam logic [MS_W-1:0] RECIP_100   = 32'd1374389535;
	localparam int              RECIP_SHIFT = 37;

	typedef struct packed {
		logic [TICK_W-1:0] delay;
		logic [TICK_W-1:0] elapsed;
	} entry_t;

endpackage

// ===== rtl/ttb_store.sv =====
// ----------------------------------------------------------------------------
// ttb_store
// Timer entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttb_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ttb_pkg::entry_t wr_entry,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ttb_pkg::entry_t rd_entry
);
	import ttb_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

// ===== rtl/ttb_scale.sv =====
// ----------------------------------------------------------------------------
// ttb_scale
// Millisecond to tick conversion: reciprocal multiply by 1/100, one stage.
// ----------------------------------------------------------------------------
module ttb_scale (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ttb_pkg::MS_W-1:0]  delay_ms,
	output logic [ttb_pkg::TICK_W-1:0] ticks
);
	import ttb_pkg::*;

	logic [2*MS_W-1:0] prod_s1;
	logic [TICK_W-1:0] quot;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= delay_ms * RECIP_100;
		end
	end

	// raise delays under one tick to one tick
	assign quot  = prod_s1[RECIP_SHIFT +: TICK_W];
	assign ticks = (quot == '0) ? TICK_W'(1) : quot;

endmodule

// ===== rtl/tick_timer_bank.sv =====
// ----------------------------------------------------------------------------
// tick_timer_bank
// Bank of one-shot countdown timers counted in 100 ms ticks.
//
// Requests enter on in_valid/in_stall with func, channel and delay_ms; results
// leave on out_valid/out_stall. Start, stop and query each load one status
// result into the output register from S_CMD after the request is taken,
// waiting in S_CMD while out_stall holds that register. A tick walks all
// NUM_TIMERS entries of the timer memory, one read-modify-write per cycle on
// each running entry, then walks the channels again up to the highest expired
// one to send one expiry result per expired channel in channel order. in_stall
// stays high through S_SCAN, S_TAIL and S_EMIT after a tick, with S_EMIT
// lengthened by expired channels and by out_stall; with no expiry no result is
// sent. The next request is taken once the previous one is finished. Timer
// state sits in a single-port-write, registered-read memory; a per-channel run
// mask marks live entries, so reset clears the bank at once and no clearing
// pass is needed. reserved_q resets to zero and is written through cfg_wr_en
// and cfg_wr_data; the user writes it only while the bank is idle, unenforced.
// ----------------------------------------------------------------------------
module tick_timer_bank #(
	parameter int NUM_TIMERS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ttb_pkg::CH_W-1:0]    cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ttb_pkg::FUNC_W-1:0]  func,
	input  logic [ttb_pkg::CH_W-1:0]    channel,
	input  logic [ttb_pkg::MS_W-1:0]    delay_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [ttb_pkg::CH_W-1:0]    channel_out,
	output logic                        accepted,
	output logic                        running,
	output logic                        any_running,
	output logic                        last
);
	import ttb_pkg::*;

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int CMP_W = ((CNT_W > CH_W) ? CNT_W : CH_W) + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMD  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_TAIL = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [CH_W-1:0]       reserved_q;
	logic [NUM_TIMERS-1:0] mask_q, mask_d;
	logic [NUM_TIMERS-1:0] exp_q;
	logic [CNT_W-1:0]      exp_cnt_q;
	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      emit_idx_q;
	logic [FUNC_W-1:0]     func_q;
	logic [CH_W-1:0]       ch_q;
	logic                  dly_nz_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic                  in_take;
	logic                  out_free;
	logic                  cmd_load, exp_load, emit_hit;
	logic                  ch_ok;
	logic [IDX_W-1:0]      ch_idx;
	logic                  cmd_acc, cmd_run;
	logic                  expire;
	logic [TICK_W-1:0]     el_new;
	logic [TICK_W-1:0]     ticks;

	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      mem_waddr;
	entry_t                mem_wdata, mem_rdata;

	logic                  out_valid_q, kind_q, acc_q, run_q, any_q, last_q;
	logic [CH_W-1:0]       ch_out_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	ttb_scale u_scale (
		.clk      (clk),
		.en       (in_take),
		.delay_ms (delay_ms),
		.ticks    (ticks)
	);

	ttb_store #(
		.DEPTH (NUM_TIMERS),
		.AW    (IDX_W)
	) u_store (
		.clk      (clk),
		.wr_en    (mem_we),
		.wr_addr  (mem_waddr),
		.wr_entry (mem_wdata),
		.rd_en    (mem_re),
		.rd_addr  (scan_idx_q),
		.rd_entry (mem_rdata)
	);

	assign ch_ok  = (ch_q > reserved_q) && (CMP_W'(ch_q) < CMP_W'(NUM_TIMERS));
	assign ch_idx = IDX_W'(ch_q);

	assign el_new = mem_rdata.elapsed + TICK_W'(1);
	assign expire = vld_s1 && (mem_rdata.delay <= el_new);

	assign mem_re   = (state_q == S_SCAN) && mask_q[scan_idx_q];
	assign cmd_load = (state_q == S_CMD) && out_free;
	assign emit_hit = (state_q == S_EMIT) && (exp_cnt_q != '0) && exp_q[emit_idx_q];
	assign exp_load = emit_hit && out_free;

	always_comb begin
		mask_d    = mask_q;
		cmd_acc   = 1'b0;
		cmd_run   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '{delay: mem_rdata.delay, elapsed: el_new};
		if (cmd_load && ch_ok) begin
			unique case (func_q)
				FUNC_START: begin
					if (dly_nz_q) begin
						mask_d[ch_idx] = 1'b1;
						mem_we         = 1'b1;
						mem_waddr      = ch_idx;
						mem_wdata      = '{delay: ticks, elapsed: '0};
						cmd_acc        = 1'b1;
					end
				end
				FUNC_STOP: begin
					mask_d[ch_idx] = 1'b0;
					cmd_acc        = 1'b1;
				end
				FUNC_QUERY: begin
					cmd_acc = 1'b1;
				end
				default: begin
				end
			endcase
			cmd_run = mask_d[ch_idx];
		end
		if (vld_s1) begin
			if (expire) begin
				mask_d[idx_s1] = 1'b0;
			end else begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			reserved_q <= '0;
			mask_q     <= '0;
			exp_cnt_q  <= '0;
			scan_idx_q <= '0;
			emit_idx_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				reserved_q <= cfg_wr_data;
			end
			mask_q <= mask_d;
			vld_s1 <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						scan_idx_q <= '0;
						exp_cnt_q  <= '0;
						state_q    <= (func == FUNC_TICK) ? S_SCAN : S_CMD;
					end
				end
				S_CMD: begin
					if (cmd_load) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_idx_q == IDX_W'(NUM_TIMERS - 1)) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					emit_idx_q <= '0;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (exp_cnt_q == '0) begin
						state_q <= S_IDLE;
					end else if (!emit_hit || exp_load) begin
						emit_idx_q <= emit_idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (expire) begin
				exp_cnt_q <= exp_cnt_q + CNT_W'(1);
			end else if (exp_load) begin
				exp_cnt_q <= exp_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q   <= func;
			ch_q     <= channel;
			dly_nz_q <= (delay_ms != '0);
			exp_q    <= '0;
		end else if (expire) begin
			exp_q[idx_s1] <= 1'b1;
		end
		idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_load || exp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) begin
			kind_q   <= 1'b1;
			ch_out_q <= ch_q;
			acc_q    <= cmd_acc;
			run_q    <= cmd_run;
			any_q    <= |mask_d;
			last_q   <= 1'b1;
		end else if (exp_load) begin
			kind_q   <= 1'b0;
			ch_out_q <= CH_W'(emit_idx_q);
			acc_q    <= 1'b0;
			run_q    <= 1'b0;
			any_q    <= |mask_q;
			last_q   <= (exp_cnt_q == CNT_W'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign channel_out = ch_out_q;
	assign accepted    = acc_q;
	assign running     = run_q;
	assign any_running = any_q;
	assign last        = last_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != scan_idx_q))
		else $error("timer memory read and write hit the same entry");

	a_expire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		expire |=> !mask_q[$past(idx_s1)])
		else $error("expired channel still marked running");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_TAIL) |-> !out_valid_q || !kind_q || !out_stall
		|| $stable(kind_q))
		else $error("output register changed during tick scan");

	a_emit_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && exp_cnt_q != '0) |-> (exp_q != '0))
		else $error("expiry count without expired channels");

endmodule
